@@ design/bfm_pkg.sv @@
// Package for the battery frame monitor.
// Holds field widths, frame ids, limits, register indexes and the divider request
// and response types. No dependencies.
package bfm_pkg;

  localparam int IdW      = 11;
  localparam int ByteW    = 8;
  localparam int SocW     = 14;
  localparam int VoltW    = 16;
  localparam int CurW     = 14;
  localparam int WhW      = 17;
  localparam int LimW     = 13;
  localparam int PwrW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Shared divider: dividend and divisor widths.
  localparam int DivW    = 21;
  localparam int DvsW    = 10;
  localparam int DivCntW = $clog2(DivW);

  localparam logic [IdW-1:0] IdCapacity = 11'h431;
  localparam logic [IdW-1:0] IdCharge   = 11'h432;
  localparam logic [IdW-1:0] IdStatus   = 11'h112;

  localparam logic [CfgIdxW-1:0] CfgMinSoc = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSoc = 2'd1;

  localparam logic [3:0]          AliveReload  = 4'd12;
  localparam logic [CurW-1:0]     CurOffset    = 14'd819;
  localparam logic [DvsW-1:0]     CapDivisor   = 10'd50;
  localparam logic [DvsW-1:0]     TenDivisor   = 10'd10;
  localparam logic [SocW-1:0]     SocHighLimit = 14'd9900;
  localparam logic [SocW-1:0]     SocLowLimit  = 14'd500;
  localparam logic [SocW-1:0]     SocMax       = 14'd10000;
  localparam logic [LimW-1:0]     LimitW       = 13'd5000;
  localparam logic [DivW-1:0]     PermilleFull = 21'd1000;
  localparam logic [CfgDataW-1:0] MinSocReset  = 10'd0;
  localparam logic [CfgDataW-1:0] MaxSocReset  = 10'd1000;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/bfm_in_if.sv @@
// Input channel of the battery frame monitor: op, frame id and six payload bytes.
// Depends on bfm_pkg.
interface bfm_in_if import bfm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [IdW-1:0]   frame_id;
  logic [ByteW-1:0] byte0;
  logic [ByteW-1:0] byte1;
  logic [ByteW-1:0] byte2;
  logic [ByteW-1:0] byte3;
  logic [ByteW-1:0] byte4;
  logic [ByteW-1:0] byte5;

  modport source (output valid, op, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                  input ready);
  modport sink (input valid, op, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                output ready);
endinterface

@@ design/bfm_out_if.sv @@
// Report channel of the battery frame monitor.
// Depends on bfm_pkg.
interface bfm_out_if import bfm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SocW-1:0]        soc_hundredths;
  logic [VoltW-1:0]       voltage_deci;
  logic signed [CurW-1:0] current_amps;
  logic [WhW-1:0]         remaining_wh;
  logic [LimW-1:0]        charge_limit_w;
  logic [LimW-1:0]        discharge_limit_w;
  logic signed [PwrW-1:0] power_watts;
  logic                   fault;

  modport source (output valid, soc_hundredths, voltage_deci, current_amps, remaining_wh,
                  charge_limit_w, discharge_limit_w, power_watts, fault,
                  input ready);
  modport sink (input valid, soc_hundredths, voltage_deci, current_amps, remaining_wh,
                charge_limit_w, discharge_limit_w, power_watts, fault,
                output ready);
endinterface

@@ design/bfm_cfg_if.sv @@
// Configuration write channel of the battery frame monitor.
// Depends on bfm_pkg.
interface bfm_cfg_if import bfm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/bfm_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on bfm_pkg for widths and the request and response structs.
module bfm_divider import bfm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivW - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0]    quo_r, quo_nxt;
  logic [DvsW-1:0]    rem_r, rem_nxt;
  logic [DvsW-1:0]    dvs_r, dvs_nxt;
  logic [DvsW:0]      trial;
  logic [DvsW:0]      diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, quo_r[DivW-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == LastStep);
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
      end
      // A failed trial leaves a value below the divisor, so it fits the remainder.
      rem_nxt = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_nxt = {quo_r[DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ design/battery_frame_monitor_unit.sv @@
// Battery frame monitor top level: sequencer, decoded state and report register.
// Depends on bfm_pkg, the three channel interfaces and bfm_divider.
//
// Usage: in_ch carries either a received bus frame (op 0) or an update tick (op 1).
// Every frame reloads the liveness counter; frames 0x431, 0x432 and 0x112 are decoded.
// Each tick produces one report on out_ch; frames produce none. cfg_ch writes the
// minimum and maximum charge bounds and is always ready; write it only while idle.
// One shared 21-step divider does all divisions, so that unit sets the rate: other ids
//   and 0x432 need no division, 0x431 needs one, 0x112 needs two in turn and a tick
//   needs one (none when the charge span is empty).
// in_ch.ready is high only while the sequencer is idle. A finished report sits in the
// output register until transferred; frames are still taken meanwhile, and a following
// tick waits at its last step until the register frees up.
// Reset (synchronous, rst_n low) clears the decoded state, sets the liveness counter to
// twelve, restores the bounds to 0 and 1000 and empties the output register.
module battery_frame_monitor_unit import bfm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  bfm_in_if.sink    in_ch,
  bfm_out_if.source out_ch,
  bfm_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAP  = 3'd1;
  localparam logic [2:0] S_CUR  = 3'd2;
  localparam logic [2:0] S_VDIV = 3'd3;
  localparam logic [2:0] S_SOC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [CfgDataW-1:0]    min_r, min_nxt;
  logic [CfgDataW-1:0]    max_r, max_nxt;
  logic [6:0]             cap_r, cap_nxt;
  logic [6:0]             disp_r, disp_nxt;
  logic signed [CurW-1:0] cur_r, cur_nxt;
  logic [VoltW-1:0]       volt_r, volt_nxt;
  logic [12:0]            vdiv_r, vdiv_nxt;
  logic [3:0]             alive_r, alive_nxt;
  logic [9:0]             q_r, q_nxt;
  logic                   fault_r, fault_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SocW-1:0]        soc_o_r, soc_o_nxt;
  logic [VoltW-1:0]       volt_o_r, volt_o_nxt;
  logic signed [CurW-1:0] cur_o_r, cur_o_nxt;
  logic [WhW-1:0]         wh_o_r, wh_o_nxt;
  logic [LimW-1:0]        chg_o_r, chg_o_nxt;
  logic [LimW-1:0]        dis_o_r, dis_o_nxt;
  logic signed [PwrW-1:0] pwr_o_r, pwr_o_nxt;
  logic                   flt_o_r, flt_o_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                   in_acc;
  logic                   out_free;
  logic [10:0]            raw;
  logic [10:0]            raw_diff;
  logic                   span_empty;
  logic [DvsW-1:0]        span;
  logic [DivW-1:0]        scaled;
  logic [SocW-1:0]        soc_fin;
  logic signed [27:0]     power_full;
  logic [WhW-1:0]         wh_fin;

  bfm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    raw        = 11'(disp_r) * 11'd10;
    raw_diff   = raw - {1'b0, min_r};
    span       = max_r - min_r;
    span_empty = (max_r <= min_r) || (raw <= {1'b0, min_r});
    scaled     = DivW'(raw_diff) * PermilleFull;
    soc_fin    = SocW'(q_r) * SocW'(10);
    power_full = cur_r * $signed({15'd0, vdiv_r});
    wh_fin     = WhW'(cap_r) * WhW'(1000);
  end

  always_comb begin
    state_nxt = state_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    cap_nxt   = cap_r;
    disp_nxt  = disp_r;
    cur_nxt   = cur_r;
    volt_nxt  = volt_r;
    vdiv_nxt  = vdiv_r;
    alive_nxt = alive_r;
    q_nxt     = q_r;
    fault_nxt = fault_r;

    div_req.start    = 1'b0;
    div_req.dividend = scaled;
    div_req.divisor  = span;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CfgMinSoc: min_nxt = cfg_ch.data;
        CfgMaxSoc: max_nxt = cfg_ch.data;
        default:   ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.op) begin
          fault_nxt = (alive_r == 4'd0);
          alive_nxt = (alive_r == 4'd0) ? 4'd0 : alive_r - 1'b1;
          if (span_empty) begin
            q_nxt     = '0;
            state_nxt = S_FIN;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_SOC;
          end
        end else if (in_acc) begin
          alive_nxt = AliveReload;
          case (in_ch.frame_id)
            IdCapacity: begin
              div_req.start    = 1'b1;
              div_req.dividend = DivW'({in_ch.byte1[3:0], in_ch.byte5});
              div_req.divisor  = CapDivisor;
              state_nxt        = S_CAP;
            end
            IdCharge: begin
              disp_nxt = in_ch.byte4[7:1];
            end
            IdStatus: begin
              volt_nxt         = {in_ch.byte3, in_ch.byte2};
              div_req.start    = 1'b1;
              div_req.dividend = DivW'({in_ch.byte1, in_ch.byte0});
              div_req.divisor  = TenDivisor;
              state_nxt        = S_CUR;
            end
            default: ;
          endcase
        end
      end
      S_CAP: begin
        if (div_rsp.done) begin
          cap_nxt   = div_rsp.quotient[6:0];
          state_nxt = S_IDLE;
        end
      end
      S_CUR: begin
        if (div_rsp.done) begin
          cur_nxt          = $signed(div_rsp.quotient[CurW-1:0]) - $signed(CurOffset);
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(volt_r);
          div_req.divisor  = TenDivisor;
          state_nxt        = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_rsp.done) begin
          vdiv_nxt  = div_rsp.quotient[12:0];
          state_nxt = S_IDLE;
        end
      end
      S_SOC: begin
        if (div_rsp.done) begin
          q_nxt     = (div_rsp.quotient > PermilleFull) ? 10'd1000
                                                         : div_rsp.quotient[9:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    soc_o_nxt     = soc_o_r;
    volt_o_nxt    = volt_o_r;
    cur_o_nxt     = cur_o_r;
    wh_o_nxt      = wh_o_r;
    chg_o_nxt     = chg_o_r;
    dis_o_nxt     = dis_o_r;
    pwr_o_nxt     = pwr_o_r;
    flt_o_nxt     = flt_o_r;
    if ((state_r == S_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
      soc_o_nxt     = soc_fin;
      volt_o_nxt    = volt_r;
      cur_o_nxt     = cur_r;
      wh_o_nxt      = wh_fin;
      chg_o_nxt     = (soc_fin > SocHighLimit) ? '0 : LimitW;
      dis_o_nxt     = (soc_fin < SocLowLimit) ? '0 : LimitW;
      pwr_o_nxt     = power_full[PwrW-1:0];
      flt_o_nxt     = fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= MinSocReset;
      max_r       <= MaxSocReset;
      cap_r       <= '0;
      disp_r      <= '0;
      cur_r       <= '0;
      volt_r      <= '0;
      vdiv_r      <= '0;
      alive_r     <= AliveReload;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      cap_r       <= cap_nxt;
      disp_r      <= disp_nxt;
      cur_r       <= cur_nxt;
      volt_r      <= volt_nxt;
      vdiv_r      <= vdiv_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r      <= q_nxt;
    fault_r  <= fault_nxt;
    soc_o_r  <= soc_o_nxt;
    volt_o_r <= volt_o_nxt;
    cur_o_r  <= cur_o_nxt;
    wh_o_r   <= wh_o_nxt;
    chg_o_r  <= chg_o_nxt;
    dis_o_r  <= dis_o_nxt;
    pwr_o_r  <= pwr_o_nxt;
    flt_o_r  <= flt_o_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.soc_hundredths    = soc_o_r;
  assign out_ch.voltage_deci      = volt_o_r;
  assign out_ch.current_amps      = cur_o_r;
  assign out_ch.remaining_wh      = wh_o_r;
  assign out_ch.charge_limit_w    = chg_o_r;
  assign out_ch.discharge_limit_w = dis_o_r;
  assign out_ch.power_watts       = pwr_o_r;
  assign out_ch.fault             = flt_o_r;

  // The divider only finishes while the sequencer is waiting on it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_CAP || state_r == S_CUR ||
                      state_r == S_VDIV || state_r == S_SOC))
    else $error("divider finished outside a wait state");

  // A received frame always reloads the liveness counter.
  a_frame_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.op) |=> (alive_r == AliveReload))
    else $error("frame did not reload liveness counter");

  // The reported charge stays within full scale and agrees with the charge limit.
  a_soc_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (soc_o_r <= SocMax) &&
                    ((chg_o_r == '0) == (soc_o_r > SocHighLimit)))
    else $error("report charge out of range or limit mismatch");

endmodule

@@ test/tb_battery_frame_monitor_unit.sv @@
// Testbench for battery_frame_monitor_unit: drives bus frames and update ticks, predicts
// each status report and checks it field by field under random idling and back-pressure.
// Depends on bfm_pkg, bfm_in_if, bfm_out_if, bfm_cfg_if and the unit itself.
module tb_battery_frame_monitor_unit import bfm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 64;
  localparam int HoldCycles = 400;

  typedef enum logic {OpFrame = 1'b0, OpTick = 1'b1} op_t;

  typedef struct packed {
    op_t              op;
    logic [IdW-1:0]   frame_id;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic [ByteW-1:0] byte2;
    logic [ByteW-1:0] byte3;
    logic [ByteW-1:0] byte4;
    logic [ByteW-1:0] byte5;
  } bus_item_t;

  typedef struct packed {
    logic [SocW-1:0]        soc;
    logic [VoltW-1:0]       volt;
    logic signed [CurW-1:0] amps;
    logic [WhW-1:0]         wh;
    logic [LimW-1:0]        chg_lim;
    logic [LimW-1:0]        dis_lim;
    logic signed [PwrW-1:0] watts;
    logic                   fault;
  } report_t;

  logic clk;
  logic rst_n;

  bfm_in_if  in_if ();
  bfm_out_if out_if ();
  bfm_cfg_if cfg_if ();

  battery_frame_monitor_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bus_item_t bus_traffic_q[$];
  report_t   report_q[$];
  bus_item_t on_bus;

  // Predicted block state and bounds.
  logic [CfgDataW-1:0]    soc_min;
  logic [CfgDataW-1:0]    soc_max;
  logic [6:0]             cap_kwh;
  logic [6:0]             disp_charge;
  logic signed [CurW-1:0] pack_amps;
  logic [VoltW-1:0]       pack_volt;
  logic [3:0]             alive_left;

  int  fail_count;
  int  reports_checked;
  int  frames_sent;
  int  ticks_sent;
  int  bound_settings;
  int  cycle_count;
  int  gap_left;
  int  stall_left;
  bit  idling;
  bit  pressure_on;
  bit  hold_on;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OpFrame;
    in_if.frame_id = '0;
    in_if.byte0 = '0;
    in_if.byte1 = '0;
    in_if.byte2 = '0;
    in_if.byte3 = '0;
    in_if.byte4 = '0;
    in_if.byte5 = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgMinSoc;
    cfg_if.data = '0;
    forever #4 clk = ~clk;
  end

  // Rescaled charge in hundredths of a percent from the current bounds.
  function automatic int unsigned scaled_charge();
    int unsigned raw;
    int unsigned q;
    raw = int'(disp_charge) * 10;
    if (soc_max <= soc_min || raw <= soc_min) return 0;
    q = (1000 * (raw - soc_min)) / (soc_max - soc_min);
    if (q > 1000) q = 1000;
    return q * 10;
  endfunction

  // Updates the predicted state for one accepted item; a tick queues its report.
  function automatic void apply_bus_item(bus_item_t it);
    report_t     rpt;
    int unsigned soc;
    int unsigned word;
    int          amps;
    logic signed [31:0] prod;
    if (it.op == OpFrame) begin
      frames_sent++;
      alive_left = AliveReload;
      if (it.frame_id == IdCapacity) begin
        word = 32'({it.byte1[3:0], it.byte5});
        cap_kwh = 7'(word / 50);
      end else if (it.frame_id == IdCharge) begin
        disp_charge = 7'(it.byte4 / 2);
      end else if (it.frame_id == IdStatus) begin
        word = 32'({it.byte1, it.byte0});
        amps = int'(word / 10) - 819;
        pack_amps = amps[CurW-1:0];
        pack_volt = {it.byte3, it.byte2};
      end
      return;
    end
    ticks_sent++;
    soc = scaled_charge();
    amps = int'(pack_amps);
    prod = amps * int'(pack_volt / 10);
    rpt.soc = soc[SocW-1:0];
    rpt.volt = pack_volt;
    rpt.amps = pack_amps;
    rpt.wh = WhW'(int'(cap_kwh) * 1000);
    rpt.chg_lim = (soc > 9900) ? '0 : LimitW;
    rpt.dis_lim = (soc < 500) ? '0 : LimitW;
    rpt.watts = prod[PwrW-1:0];
    if (alive_left == 4'd0) begin
      rpt.fault = 1'b1;
    end else begin
      alive_left = alive_left - 4'd1;
      rpt.fault = 1'b0;
    end
    report_q.push_back(rpt);
  endfunction

  // Input driver: holds an offered item until its transfer, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) apply_bus_item(on_bus);
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (bus_traffic_q.size() != 0 && idling && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 11);
        in_if.valid <= 1'b0;
      end else if (bus_traffic_q.size() != 0) begin
        on_bus = bus_traffic_q.pop_front();
        in_if.op <= on_bus.op;
        in_if.frame_id <= on_bus.frame_id;
        in_if.byte0 <= on_bus.byte0;
        in_if.byte1 <= on_bus.byte1;
        in_if.byte2 <= on_bus.byte2;
        in_if.byte3 <= on_bus.byte3;
        in_if.byte4 <= on_bus.byte4;
        in_if.byte5 <= on_bus.byte5;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Report receiver: random stall bursts, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_on) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    hold_on = 1'b0;
    wait (pressure_on);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    hold_on = 1'b0;
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.soc = out_if.soc_hundredths;
      got.volt = out_if.voltage_deci;
      got.amps = out_if.current_amps;
      got.wh = out_if.remaining_wh;
      got.chg_lim = out_if.charge_limit_w;
      got.dis_lim = out_if.discharge_limit_w;
      got.watts = out_if.power_watts;
      got.fault = out_if.fault;
      if (report_q.size() == 0) begin
        if (fail_count < 10) $display("ERROR: report with none expected: %p", got);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        reports_checked++;
        if (got.soc !== want.soc || got.volt !== want.volt || got.amps !== want.amps ||
            got.wh !== want.wh || got.chg_lim !== want.chg_lim ||
            got.dis_lim !== want.dis_lim || got.watts !== want.watts ||
            got.fault !== want.fault) begin
          if (fail_count < 10) begin
            $display("ERROR: report %0d mismatch", reports_checked);
            $display("  expected soc=%0d volt=%0d amps=%0d wh=%0d chg=%0d dis=%0d pwr=%0d flt=%0b",
                     want.soc, want.volt, want.amps, want.wh, want.chg_lim, want.dis_lim,
                     want.watts, want.fault);
            $display("  actual   soc=%0d volt=%0d amps=%0d wh=%0d chg=%0d dis=%0d pwr=%0d flt=%0b",
                     got.soc, got.volt, got.amps, got.wh, got.chg_lim, got.dis_lim,
                     got.watts, got.fault);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d reports still expected", cycle_count,
               report_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CfgMinSoc) soc_min = val;
    else soc_max = val;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_frame(input logic [IdW-1:0] id, input logic [ByteW-1:0] b0,
                            input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2,
                            input logic [ByteW-1:0] b3, input logic [ByteW-1:0] b4,
                            input logic [ByteW-1:0] b5);
    bus_item_t it;
    it = '{OpFrame, id, b0, b1, b2, b3, b4, b5};
    bus_traffic_q.push_back(it);
  endtask

  // Payload fields of a tick are ignored by the block, so they carry noise.
  task automatic push_tick();
    bus_item_t it;
    it = bus_item_t'({$urandom, $urandom});
    it.op = OpTick;
    bus_traffic_q.push_back(it);
  endtask

  task automatic push_random(input int tick_pct);
    logic [IdW-1:0] id;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      push_tick();
    end else begin
      case ($urandom_range(0, 5))
        0, 1: id = IdCharge;
        2:    id = IdCapacity;
        3:    id = IdStatus;
        4:    id = IdStatus ^ IdW'(1 << $urandom_range(0, IdW - 1));
        default: id = IdW'($urandom);
      endcase
      push_frame(id, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                 ByteW'($urandom), ByteW'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (bus_traffic_q.size() != 0 || in_if.valid || report_q.size() != 0)
      @(negedge clk);
    // A status frame can still be dividing after the last report came out.
    repeat (SettleCycles) @(negedge clk);
  endtask

  // One bound setting followed by random traffic; runs of silent ticks can reach the fault.
  task automatic run_phase(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                           input int count, input int tick_pct);
    int pushed;
    int run;
    write_reg(CfgMinSoc, lo);
    write_reg(CfgMaxSoc, hi);
    bound_settings++;
    pushed = 0;
    @(negedge clk);
    while (pushed < count) begin
      if ($urandom_range(0, 24) == 0) begin
        run = $urandom_range(11, 14);
        repeat (run) push_tick();
        pushed += run;
      end else begin
        push_random(tick_pct);
        pushed++;
      end
    end
    wait_drained();
  endtask

  initial begin
    soc_min = MinSocReset;
    soc_max = MaxSocReset;
    cap_kwh = '0;
    disp_charge = '0;
    pack_amps = '0;
    pack_volt = '0;
    alive_left = AliveReload;
    fail_count = 0;
    reports_checked = 0;
    frames_sent = 0;
    ticks_sent = 0;
    bound_settings = 1;
    cycle_count = 0;
    idling = 1'b1;
    pressure_on = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset bounds.
    push_tick();
    push_frame(IdCapacity, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF);
    push_frame(IdCharge, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
    push_frame(IdStatus, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
    push_tick();
    push_frame(IdStatus, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
    push_frame(IdCapacity, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    push_frame(IdCharge, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    push_tick();
    // Charge right at the upper and lower thresholds, then just below the lower one.
    push_frame(IdCharge, 8'h00, 8'h00, 8'h00, 8'h00, 8'd198, 8'h00);
    push_tick();
    push_frame(IdCharge, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10, 8'h00);
    push_tick();
    push_frame(IdCharge, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 8'h00);
    push_frame(11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Twelve silent ticks stay healthy, the thirteenth reports the fault.
    repeat (13) push_tick();
    wait_drained();

    run_phase(10'd100, 10'd900, 60, 35);
    run_phase(10'd1023, 10'd0, 40, 35);
    run_phase(10'd500, 10'd500, 30, 35);
    run_phase(10'd0, 10'd1023, 50, 35);
    run_phase(10'd1022, 10'd1023, 40, 35);
    pressure_on = 1'b1;
    run_phase(10'd200, 10'd800, 60, 60);
    run_phase(CfgDataW'($urandom_range(0, 1023)), CfgDataW'($urandom_range(0, 1023)), 50, 35);
    run_phase(CfgDataW'($urandom_range(0, 600)), CfgDataW'($urandom_range(400, 1023)), 50, 35);
    idling = 1'b0;
    run_phase(MinSocReset, MaxSocReset, 60, 35);

    if (report_q.size() != 0) begin
      $display("ERROR: %0d reports never arrived", report_q.size());
      fail_count += report_q.size();
    end
    $display("Sent %0d frames and %0d ticks over %0d bound settings; %0d reports checked.",
             frames_sent, ticks_sent, bound_settings, reports_checked);
    $display("Bounds covered empty, equal and over-range spans; one long receiver hold-off.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bfm_pkg.sv
design/bfm_in_if.sv
design/bfm_out_if.sv
design/bfm_cfg_if.sv
design/bfm_divider.sv
design/battery_frame_monitor_unit.sv
test/tb_battery_frame_monitor_unit.sv
